// ===== src/assert_macros.svh =====
// assertion helpers used by vkp_out_buf
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on the same edge
`define VKP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked on the next edge
`define VKP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/vkp_pkg.sv =====
// ----------------------------------------------------------------------------
// vkp_pkg
// types, codes and constants of the vpd keyword stream parser
// ----------------------------------------------------------------------------
package vkp_pkg;

    localparam logic [7:0]  TAG_END     = 8'h78;
    localparam logic [7:0]  TAG_RO      = 8'h90;
    localparam logic [7:0]  TAG_RW      = 8'h91;
    localparam logic [16:0] CONSUMED_MAX = 17'h1FFFF;
    localparam logic [15:0] BUDGET_RESET = 16'h8000;

    typedef enum logic [3:0] {
        PH_TAG   = 4'd0,
        PH_LENLO = 4'd1,
        PH_LENHI = 4'd2,
        PH_SKIP  = 4'd3,
        PH_KEY0  = 4'd4,
        PH_KEY1  = 4'd5,
        PH_KLEN  = 4'd6,
        PH_DATA  = 4'd7,
        PH_DONE  = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        EV_DATA    = 3'd0,
        EV_EMPTY   = 3'd1,
        EV_END     = 3'd2,
        EV_OVERRUN = 3'd3,
        EV_BUDGET  = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        REG_FILTER_ENABLE = 2'd0,
        REG_WANTED_KEY    = 2'd1,
        REG_BYTE_BUDGET   = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic        filter_enable;
        logic [15:0] wanted_key;
        logic [15:0] byte_budget;
    } cfg_t;

    typedef struct packed {
        event_t      event_res;
        logic [15:0] entry_key;
        logic [7:0]  data_byte;
        logic [7:0]  data_index;
        logic [7:0]  data_length;
        logic        last_of_keyword;
    } result_t;

endpackage

// ===== src/vkp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// vkp_cfg_regs
// apb register file: filter enable, wanted key, byte budget
// ----------------------------------------------------------------------------
module vkp_cfg_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output vkp_pkg::cfg_t      cfg
);

    vkp_pkg::cfg_t    cfg_reg;
    vkp_pkg::reg_idx_t idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = vkp_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.filter_enable <= 1'b0;
            cfg_reg.wanted_key    <= 16'h0000;
            cfg_reg.byte_budget   <= vkp_pkg::BUDGET_RESET;
        end else if (wr_en) begin
            unique case (idx)
                vkp_pkg::REG_FILTER_ENABLE: cfg_reg.filter_enable <= pwdata[0];
                vkp_pkg::REG_WANTED_KEY:    cfg_reg.wanted_key    <= pwdata[15:0];
                vkp_pkg::REG_BYTE_BUDGET:   cfg_reg.byte_budget   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            vkp_pkg::REG_FILTER_ENABLE: prdata = {31'b0, cfg_reg.filter_enable};
            vkp_pkg::REG_WANTED_KEY:    prdata = {16'b0, cfg_reg.wanted_key};
            vkp_pkg::REG_BYTE_BUDGET:   prdata = {16'b0, cfg_reg.byte_budget};
            default:                    prdata = 32'h0;
        endcase
    end

endmodule

// ===== src/vkp_parser.sv =====
// ----------------------------------------------------------------------------
// vkp_parser
// resource tag walk, one vpd byte per accepted request
// ----------------------------------------------------------------------------
module vkp_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic [7:0]       vpd_byte,
    input  logic             first,
    input  vkp_pkg::cfg_t    cfg,
    output logic             res_valid,
    output vkp_pkg::result_t res
);

    typedef struct packed {
        vkp_pkg::phase_t phase;
        logic [15:0]     remaining;
        logic [16:0]     consumed;
        logic [7:0]      length_low;
        logic            in_kw_list;
        logic [15:0]     key;
        logic [7:0]      length;
        logic [7:0]      index;
        logic            key_matches;
    } pstate_t;

    localparam pstate_t CLEAR_STATE = '{
        phase: vkp_pkg::PH_TAG, remaining: 16'h0, consumed: 17'h0,
        length_low: 8'h0, in_kw_list: 1'b0, key: 16'h0, length: 8'h0,
        index: 8'h0, key_matches: 1'b0};

    pstate_t st_reg, st_next, cur;
    logic    hit_next;
    vkp_pkg::result_t res_next;

    function automatic logic [16:0] sat_add(input logic [16:0] a, input logic [17:0] n);
        logic [17:0] s;
        s = {1'b0, a} + n;
        return (s > {1'b0, vkp_pkg::CONSUMED_MAX}) ? vkp_pkg::CONSUMED_MAX : s[16:0];
    endfunction

    logic [15:0] big_len;
    logic [8:0]  entry_len;
    logic [8:0]  idx_inc;
    logic        last_byte;
    logic        filt;

    assign big_len   = {vpd_byte, cur.length_low};
    assign entry_len = 9'd3 + {1'b0, vpd_byte};
    assign idx_inc   = {1'b0, cur.index} + 9'd1;
    assign last_byte = idx_inc >= {1'b0, cur.length};
    assign filt      = cfg.filter_enable;

    always_comb begin
        cur      = first ? CLEAR_STATE : st_reg;
        st_next  = cur;
        hit_next = 1'b0;
        res_next = '{event_res: vkp_pkg::EV_DATA, entry_key: 16'h0, data_byte: 8'h0,
                     data_index: 8'h0, data_length: 8'h0, last_of_keyword: 1'b0};
        unique case (cur.phase)
            vkp_pkg::PH_TAG: begin
                if (cur.consumed >= {1'b0, cfg.byte_budget}) begin
                    st_next.phase      = vkp_pkg::PH_DONE;
                    hit_next           = 1'b1;
                    res_next.event_res = vkp_pkg::EV_BUDGET;
                end else if (vpd_byte == vkp_pkg::TAG_END) begin
                    st_next.consumed   = sat_add(cur.consumed, 18'd1);
                    st_next.phase      = vkp_pkg::PH_DONE;
                    hit_next           = 1'b1;
                    res_next.event_res = vkp_pkg::EV_END;
                end else if (vpd_byte[7]) begin
                    st_next.consumed   = sat_add(cur.consumed, 18'd1);
                    st_next.in_kw_list = (vpd_byte == vkp_pkg::TAG_RO) ||
                                         (vpd_byte == vkp_pkg::TAG_RW);
                    st_next.phase      = vkp_pkg::PH_LENLO;
                end else begin
                    // small tag: tag byte plus its 3-bit length
                    st_next.consumed   = sat_add(cur.consumed, 18'd1 + 18'(vpd_byte[2:0]));
                    st_next.in_kw_list = 1'b0;
                    st_next.remaining  = 16'(vpd_byte[2:0]);
                    st_next.phase      = (vpd_byte[2:0] == 3'd0) ? vkp_pkg::PH_TAG
                                                                 : vkp_pkg::PH_SKIP;
                end
            end
            vkp_pkg::PH_LENLO: begin
                st_next.length_low = vpd_byte;
                st_next.phase      = vkp_pkg::PH_LENHI;
            end
            vkp_pkg::PH_LENHI: begin
                st_next.consumed  = sat_add(cur.consumed, 18'd2 + 18'(big_len));
                st_next.remaining = big_len;
                if (big_len == 16'h0)
                    st_next.phase = vkp_pkg::PH_TAG;
                else
                    st_next.phase = cur.in_kw_list ? vkp_pkg::PH_KEY0 : vkp_pkg::PH_SKIP;
            end
            vkp_pkg::PH_SKIP: begin
                st_next.remaining = cur.remaining - 16'd1;
                if (cur.remaining == 16'd1)
                    st_next.phase = vkp_pkg::PH_TAG;
            end
            vkp_pkg::PH_KEY0: begin
                st_next.key   = {8'h00, vpd_byte};
                st_next.phase = vkp_pkg::PH_KEY1;
            end
            vkp_pkg::PH_KEY1: begin
                st_next.key   = {vpd_byte, cur.key[7:0]};
                st_next.phase = vkp_pkg::PH_KLEN;
            end
            vkp_pkg::PH_KLEN: begin
                st_next.length = vpd_byte;
                st_next.index  = 8'h0;
                res_next.entry_key   = cur.key;
                res_next.data_length = vpd_byte;
                if ({7'b0, entry_len} > cur.remaining) begin
                    st_next.phase      = vkp_pkg::PH_DONE;
                    hit_next           = 1'b1;
                    res_next.event_res = vkp_pkg::EV_OVERRUN;
                end else begin
                    st_next.remaining   = cur.remaining - {7'b0, entry_len};
                    st_next.key_matches = (cur.key == cfg.wanted_key);
                    res_next.event_res       = vkp_pkg::EV_EMPTY;
                    res_next.last_of_keyword = 1'b1;
                    if (vpd_byte != 8'h0) begin
                        st_next.phase = vkp_pkg::PH_DATA;
                    end else if (filt && st_next.key_matches) begin
                        st_next.phase = vkp_pkg::PH_DONE;
                        hit_next      = 1'b1;
                    end else begin
                        hit_next      = !filt;
                        st_next.phase = (st_next.remaining == 16'h0) ? vkp_pkg::PH_TAG
                                                                     : vkp_pkg::PH_KEY0;
                    end
                end
            end
            vkp_pkg::PH_DATA: begin
                st_next.index = idx_inc[7:0];
                if (last_byte) begin
                    if (filt && cur.key_matches)
                        st_next.phase = vkp_pkg::PH_DONE;
                    else
                        st_next.phase = (cur.remaining == 16'h0) ? vkp_pkg::PH_TAG
                                                                 : vkp_pkg::PH_KEY0;
                end
                hit_next                 = !filt || cur.key_matches;
                res_next.entry_key       = cur.key;
                res_next.data_byte       = vpd_byte;
                res_next.data_index      = cur.index;
                res_next.data_length     = cur.length;
                res_next.last_of_keyword = last_byte;
            end
            default: begin
                st_next.phase = vkp_pkg::PH_DONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= CLEAR_STATE;
        end else if (in_valid) begin
            st_reg <= st_next;
        end
    end

    assign res_valid = in_valid && hit_next;
    assign res       = res_next;

endmodule

// ===== src/vkp_out_buf.sv =====
// ----------------------------------------------------------------------------
// vkp_out_buf
// result register with one skid entry between parser and master side
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vkp_out_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  vkp_pkg::result_t push_data,
    output logic             ready,
    output logic             out_valid,
    output vkp_pkg::result_t out_data,
    input  logic             out_ready
);

    logic             main_valid_reg;
    logic             skid_valid_reg;
    vkp_pkg::result_t main_reg;
    vkp_pkg::result_t skid_reg;
    logic             pop;

    assign pop       = main_valid_reg && out_ready;
    assign ready     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= push;
            end
        end else if (!main_valid_reg) begin
            main_valid_reg <= push;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && skid_valid_reg) begin
            main_reg <= skid_reg;
        end else if (pop || !main_valid_reg) begin
            main_reg <= push_data;
        end
        if (!pop && main_valid_reg && push) begin
            skid_reg <= push_data;
        end
    end

    `VKP_ASSERT_IMP(a_skid_needs_main, aclk, aresetn, skid_valid_reg, main_valid_reg)
    `VKP_ASSERT_IMP(a_push_only_when_ready, aclk, aresetn, push, ready)
    `VKP_ASSERT_NXT(a_stall_fills_skid, aclk, aresetn,
        main_valid_reg && !out_ready && push, skid_valid_reg)

endmodule

// ===== src/vpd_keyword_stream_parser_core.sv =====
// ----------------------------------------------------------------------------
// vpd_keyword_stream_parser_core
// pci vpd resource walk with keyword entry events
// ----------------------------------------------------------------------------
// Takes one VPD byte per cycle on the slave stream while s_tready is high
// (tuser marks offset 0 and restarts the walk) and emits at most one event
// per byte on the master stream. Combinational parse logic between the phase
// registers and the result register handles each byte. The two-entry result
// buffer keeps the input taking one byte every cycle while a result waits;
// input stalls only when both entries are full. The user must see that APB
// registers are written only while idle; the block does not enforce it.
module vpd_keyword_stream_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] vpd_byte
    input  logic        s_tuser,   // [0] first
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] entry_key, [23:16] data_byte,
                                   // [31:24] data_index, [39:32] data_length
    output logic [2:0]  m_tuser,   // [2:0] event_res
    output logic        m_tlast,   // last_of_keyword
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    vkp_pkg::cfg_t    cfg;
    vkp_pkg::result_t res;
    vkp_pkg::result_t out_res;
    logic             res_valid;
    logic             accept;

    assign accept = s_tvalid && s_tready;

    vkp_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vkp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .vpd_byte  (s_tdata),
        .first     (s_tuser),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    vkp_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {out_res.data_length, out_res.data_index,
                      out_res.data_byte, out_res.entry_key};
    assign m_tuser = out_res.event_res;
    assign m_tlast = out_res.last_of_keyword;

endmodule

// ===== tb/sv/vpd_walk_checker.sv =====
// ----------------------------------------------------------------------------
// vpd_walk_checker
// watches the vpd byte stream, the event stream and the register port,
// walks the vpd resources on its own and compares every event in order
// ----------------------------------------------------------------------------
module vpd_walk_checker import vkp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending,
    output int          result_count
);

    result_t     event_q[$];

    // register copies
    logic        filt_on;
    logic [15:0] want_key;
    logic [15:0] budget;

    // walk state
    phase_t      walk_phase;
    logic [15:0] res_left;
    logic [16:0] used_bytes;
    logic [7:0]  len_lo;
    logic        kw_list;
    logic [15:0] cur_key;
    logic [7:0]  cur_len;
    logic [7:0]  cur_idx;
    logic        key_hit;

    result_t     exp_r;
    result_t     got_r;
    string       bad;

    function automatic void restart_walk();
        walk_phase = PH_TAG;
        res_left   = '0;
        used_bytes = '0;
        len_lo     = '0;
        kw_list    = 1'b0;
        cur_key    = '0;
        cur_len    = '0;
        cur_idx    = '0;
        key_hit    = 1'b0;
    endfunction

    // consumed count saturates instead of wrapping
    function automatic void charge(input int unsigned n);
        int unsigned s;
        s = used_bytes + n;
        used_bytes = (s > CONSUMED_MAX) ? CONSUMED_MAX : s[16:0];
    endfunction

    function automatic void next_entry();
        walk_phase = (res_left == 0) ? PH_TAG : PH_KEY0;
    endfunction

    // returns 1 when the byte produces an event
    function automatic bit walk_byte(input logic [7:0] b, input logic restart,
                                     output result_t r);
        int unsigned n;
        bit          fin;
        r = '0;
        if (restart) restart_walk();
        case (walk_phase)
            PH_TAG: begin
                if (used_bytes >= {1'b0, budget}) begin
                    walk_phase = PH_DONE;
                    r.event_res = EV_BUDGET;
                    return 1'b1;
                end
                charge(1);
                if (b == TAG_END) begin
                    walk_phase = PH_DONE;
                    r.event_res = EV_END;
                    return 1'b1;
                end
                if (b[7]) begin
                    kw_list = (b == TAG_RO) || (b == TAG_RW);
                    walk_phase = PH_LENLO;
                end else begin
                    n = b[2:0];
                    kw_list = 1'b0;
                    charge(n);
                    res_left = 16'(n);
                    walk_phase = (n == 0) ? PH_TAG : PH_SKIP;
                end
                return 1'b0;
            end
            PH_LENLO: begin
                len_lo = b;
                walk_phase = PH_LENHI;
                return 1'b0;
            end
            PH_LENHI: begin
                n = {b, len_lo};
                charge(2 + n);
                res_left = {b, len_lo};
                if (n == 0) walk_phase = PH_TAG;
                else walk_phase = kw_list ? PH_KEY0 : PH_SKIP;
                return 1'b0;
            end
            PH_SKIP: begin
                res_left = res_left - 16'd1;
                if (res_left == 0) walk_phase = PH_TAG;
                return 1'b0;
            end
            PH_KEY0: begin
                cur_key = {8'h00, b};
                walk_phase = PH_KEY1;
                return 1'b0;
            end
            PH_KEY1: begin
                cur_key = {b, cur_key[7:0]};
                walk_phase = PH_KLEN;
                return 1'b0;
            end
            PH_KLEN: begin
                cur_len = b;
                cur_idx = '0;
                // overrun wins over a filter match
                if (int'(b) + 3 > int'(res_left)) begin
                    walk_phase = PH_DONE;
                    r.event_res = EV_OVERRUN;
                    r.entry_key = cur_key;
                    r.data_length = b;
                    return 1'b1;
                end
                res_left = res_left - 16'(b) - 16'd3;
                key_hit = (cur_key == want_key);
                if (b != 0) begin
                    walk_phase = PH_DATA;
                    return 1'b0;
                end
                if (filt_on && !key_hit) begin
                    next_entry();
                    return 1'b0;
                end
                if (filt_on) walk_phase = PH_DONE;
                else next_entry();
                r.event_res = EV_EMPTY;
                r.entry_key = cur_key;
                r.last_of_keyword = 1'b1;
                return 1'b1;
            end
            PH_DATA: begin
                fin = (int'(cur_idx) + 1) >= int'(cur_len);
                r.event_res = EV_DATA;
                r.entry_key = cur_key;
                r.data_byte = b;
                r.data_index = cur_idx;
                r.data_length = cur_len;
                r.last_of_keyword = fin;
                cur_idx = cur_idx + 8'd1;
                if (fin) begin
                    if (filt_on && key_hit) walk_phase = PH_DONE;
                    else next_entry();
                end
                return !filt_on || key_hit;
            end
            default: begin
                walk_phase = PH_DONE;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void note_failure(input string what, input result_t e,
                                         input result_t g);
        fail_count++;
        if (fail_count <= 10) begin
            $display("mismatch %0d at %0t: %s", fail_count, $realtime, what);
            $display("  expected ev=%0d key=%h byte=%h idx=%0d len=%0d last=%0b",
                     e.event_res, e.entry_key, e.data_byte, e.data_index,
                     e.data_length, e.last_of_keyword);
            $display("  got      ev=%0d key=%h byte=%h idx=%0d len=%0d last=%0b",
                     g.event_res, g.entry_key, g.data_byte, g.data_index,
                     g.data_length, g.last_of_keyword);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            filt_on      = 1'b0;
            want_key     = '0;
            budget       = BUDGET_RESET;
            restart_walk();
            event_q.delete();
            fail_count   = 0;
            result_count = 0;
            pending     <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_FILTER_ENABLE: filt_on  = pwdata[0];
                    REG_WANTED_KEY:    want_key = pwdata[15:0];
                    REG_BYTE_BUDGET:   budget   = pwdata[15:0];
                    default: ;
                endcase
            end
            // events seen now belong to bytes taken on earlier edges
            if (m_tvalid && m_tready) begin
                got_r.event_res       = event_t'(m_tuser);
                got_r.entry_key       = m_tdata[15:0];
                got_r.data_byte       = m_tdata[23:16];
                got_r.data_index      = m_tdata[31:24];
                got_r.data_length     = m_tdata[39:32];
                got_r.last_of_keyword = m_tlast;
                result_count++;
                if (event_q.size() == 0) begin
                    note_failure("event with none expected", '0, got_r);
                end else begin
                    exp_r = event_q.pop_front();
                    bad = "";
                    if (got_r.event_res != exp_r.event_res) bad = {bad, " event_res"};
                    if (got_r.entry_key != exp_r.entry_key) bad = {bad, " entry_key"};
                    if (got_r.data_byte != exp_r.data_byte) bad = {bad, " data_byte"};
                    if (got_r.data_index != exp_r.data_index) bad = {bad, " data_index"};
                    if (got_r.data_length != exp_r.data_length) bad = {bad, " data_length"};
                    if (got_r.last_of_keyword != exp_r.last_of_keyword)
                        bad = {bad, " last_of_keyword"};
                    if (bad != "") note_failure({"wrong", bad}, exp_r, got_r);
                end
            end
            if (s_tvalid && s_tready) begin
                if (walk_byte(s_tdata, s_tuser, exp_r)) event_q.push_back(exp_r);
            end
            pending <= event_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_vpd_keyword_stream_parser_core.sv =====
// ----------------------------------------------------------------------------
// tb_vpd_keyword_stream_parser_core
// feeds vpd images through the keyword parser under several register settings
// ----------------------------------------------------------------------------
// A short hand-built walk hits every tag kind, empty and filled keywords, an
// overrun, the done state and a restart. Then random images (mostly
// well-formed resource lists, some noise and cut-off walks) run under filter,
// wanted-key and budget settings, with random gaps and stalls on both streams.
// The checker beside the block predicts and compares all events.
module tb_vpd_keyword_stream_parser_core;
    import vkp_pkg::*;

    localparam int QUIET_LIMIT = 500;
    localparam int DRAIN       = 8;
    localparam int PHASES      = 8;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] vpd_byte
    logic        s_tuser  = 1'b0; // [0] first
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // [15:0] key, [23:16] byte, [31:24] index,
                                  // [39:32] length
    logic [2:0]  m_tuser;         // [2:0] event_res
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          result_count;
    int          bytes_sent = 0;
    int          settings   = 0;
    int          quiet      = 0;
    bit          gaps_on    = 1'b0;
    bit          stalls_on  = 1'b0;
    bit          img_first  = 1'b0;
    logic [8:0]  vpd_img[$];      // {first, byte}

    localparam logic [7:0] WALK_A [24] = '{
        8'h79, 8'hFF,                      // masked small tag, one skipped byte
        8'h90, 8'h00, 8'h00,               // read-only resource of length zero
        8'h82, 8'h01, 8'h00, 8'hA5,        // other large resource, skipped
        8'h91, 8'h0A, 8'h00,               // read-write list of ten bytes
        8'h56, 8'h30, 8'h00,               // empty keyword
        8'h53, 8'h4E, 8'h02, 8'h00, 8'hFF, // two data bytes
        8'h59, 8'h5A, 8'h05,               // entry runs past the resource
        8'h55                              // ignored once done
    };

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    vpd_keyword_stream_parser_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    vpd_walk_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count)
    );

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pwrite)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        wait (quiet >= QUIET_LIMIT);
        $display("timeout: no handshake for %0d cycles, %0d events still due",
                 QUIET_LIMIT, pending);
        $display("CHECKS FAILED");
        $finish;
    end

    // event side: ready in random bursts, stalls only while allowed
    initial begin
        forever begin
            if (stalls_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    end

    function automatic void put(input logic [7:0] b);
        vpd_img.push_back({img_first, b});
        img_first = 1'b0;
    endfunction

    function automatic void add_small();
        logic [3:0] name;
        logic [2:0] len;
        name = 4'($urandom);
        len  = 3'($urandom);
        // keep clear of the end tag
        if (name == 4'hF && len == 3'd0) len = 3'($urandom_range(1, 7));
        put({1'b0, name, len});
        repeat (len) put(8'($urandom));
    endfunction

    function automatic void add_other_large();
        logic [7:0] tag;
        int         len;
        tag = 8'h80 | 8'($urandom);
        if (tag == TAG_RO || tag == TAG_RW) tag = 8'h82;
        len = $urandom_range(0, 12);
        put(tag);
        put(8'(len));
        put(8'h00);
        repeat (len) put(8'($urandom));
    endfunction

    function automatic void add_keyword_list(input logic [15:0] hit_key);
        logic [7:0]  body[$];
        logic [15:0] k;
        int          n_ent;
        int          elen;
        int          total;
        int          rlen;
        int          slack;
        n_ent = $urandom_range(0, 4);
        for (int i = 0; i < n_ent; i++) begin
            k = ($urandom_range(0, 2) == 0) ? hit_key : 16'($urandom);
            elen = ($urandom_range(0, 39) == 0) ? $urandom_range(200, 255)
                                                : $urandom_range(0, 9);
            body.push_back(k[7:0]);
            body.push_back(k[15:8]);
            body.push_back(8'(elen));
            repeat (elen) body.push_back(8'($urandom));
        end
        total = body.size();
        rlen = total;
        case ($urandom_range(0, 9))
            0: begin
                // resource too short for its last entry
                if (total > 0) rlen = total - $urandom_range(1, (total > 3) ? 3 : total);
            end
            1: begin
                slack = $urandom_range(1, 2);
                rlen = total + slack;
                repeat (slack) body.push_back(8'($urandom));
            end
            default: ;
        endcase
        put($urandom_range(0, 1) ? TAG_RW : TAG_RO);
        put(rlen[7:0]);
        put(rlen[15:8]);
        foreach (body[i]) put(body[i]);
    endfunction

    function automatic void build_image(input logic [15:0] hit_key);
        int n_res;
        img_first = 1'b1;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 20)) put(8'($urandom));
            return;
        end
        n_res = $urandom_range(0, 4);
        repeat (n_res) begin
            case ($urandom_range(0, 5))
                0:       add_small();
                1:       add_other_large();
                default: add_keyword_list(hit_key);
            endcase
        end
        // most walks end cleanly, the rest are cut off by the next restart
        if ($urandom_range(0, 7) != 0) begin
            put(TAG_END);
            if ($urandom_range(0, 7) == 0) put(8'($urandom));
        end
    endfunction

    task automatic send_byte(input logic [8:0] it);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it[8];
        s_tdata  <= it[7:0];
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    // sends the image until the byte count reaches limit, the rest is dropped
    task automatic send_image(input int limit);
        while (vpd_img.size() != 0 && bytes_sent < limit) send_byte(vpd_img.pop_front());
        vpd_img.delete();
    endtask

    // wait until every expected event is out and the block is quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        logic        fe;
        logic [15:0] wk;
        logic [15:0] bg;
        int          quota;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // hand-built walk under reset settings, then a restart onto the end tag
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        img_first = 1'b1;
        foreach (WALK_A[i]) put(WALK_A[i]);
        img_first = 1'b1;
        put(TAG_END);
        send_image(bytes_sent + vpd_img.size());
        settle();
        settings++;

        // the spare address must not disturb anything
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);

        for (int p = 0; p < PHASES; p++) begin
            fe = p[0];
            wk = 16'($urandom);
            quota = 115;
            case (p)
                0: begin wk = 16'hFFFF; bg = 16'hFFFF; end
                1: begin wk = 16'h0000; bg = BUDGET_RESET; end
                2: begin wk = 16'hFFFF; bg = 16'd1; end
                3: begin fe = 1'b0; bg = 16'd0; quota = 30; end
                4: bg = 16'($urandom_range(8, 64));
                5: bg = 16'($urandom_range(16, 200));
                6: bg = 16'd8000;
                default: begin wk = 16'h0000; bg = BUDGET_RESET; end
            endcase
            apb_write(REG_FILTER_ENABLE, {31'd0, fe});
            apb_write(REG_WANTED_KEY, {16'd0, wk});
            apb_write(REG_BYTE_BUDGET, {16'd0, bg});
            settings++;
            quota = bytes_sent + quota;
            while (bytes_sent < quota) begin
                // the closing phase runs with no gaps or stalls
                gaps_on   = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
                stalls_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
                build_image(wk);
                send_image(quota);
            end
            settle();
        end

        $display("run: %0d vpd bytes over %0d register settings, %0d events compared",
                 bytes_sent, settings, result_count);
        $display("run: small, large and keyword resources, filter stops, overruns, budgets");
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
